// ----- rtl/handle_table_engine_unit_assert.svh -----
// Assertion macros for the handle table engine.
// Included by the top level; no other dependencies.
`ifndef HANDLE_TABLE_ENGINE_UNIT_ASSERT_SVH
`define HANDLE_TABLE_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication under async active-low reset.
`define HTE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("hte assertion failed");

// Next-cycle implication under async active-low reset.
`define HTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("hte assertion failed");

`endif

// ----- rtl/hte_pkg.sv -----
// Shared types and constants for the handle table engine.
// No dependencies.
package hte_pkg;

	localparam int ENTRIES_DEF = 64;

	localparam int DATA_W = 144;   // both streams, padded to whole bytes
	localparam int USER_W = 2;

	// operation codes
	localparam logic [1:0] OP_CREATE   = 2'd0;
	localparam logic [1:0] OP_REFERENCE = 2'd1;
	localparam logic [1:0] OP_CLOSE    = 2'd2;
	localparam logic [1:0] OP_SETFLAGS = 2'd3;

	// result status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_INVALID = 3'd1;
	localparam logic [2:0] ST_TYPE    = 3'd2;
	localparam logic [2:0] ST_ACCESS  = 3'd3;
	localparam logic [2:0] ST_NOCLOSE = 3'd4;
	localparam logic [2:0] ST_NORES   = 3'd5;

	// pseudo handles: this value and above
	localparam logic [31:0] PSEUDO_FIRST = 32'hFFFF_FFFA;

	// attribute bit positions
	localparam int ATTR_PROTECT_BIT = 0;
	localparam int ATTR_INHERIT_BIT = 1;

	typedef struct packed {
		logic [31:0] object_id;
		logic [7:0]  object_type;
		logic [31:0] access;
		logic [31:0] attributes;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// controller -> datapath
	typedef struct packed {
		logic accept;    // capture input word, issue entry read
		logic execute;   // evaluate, update table, load result register
	} cmd_t;

endpackage

// ----- rtl/hte_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/hte_ctrl.sv -----
// Controller for the handle table engine: accept / execute sequencing
// and result-valid tracking. Uses hte_pkg.
module hte_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output hte_pkg::cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic out_valid_q;
	logic out_free;

	assign in_ready    = (state_q == ST_IDLE);
	assign out_free    = !out_valid_q || out_ready;
	assign cmd.accept  = in_valid && in_ready;
	assign cmd.execute = (state_q == ST_EXEC) && out_free;
	assign out_valid   = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.accept) state_q <= ST_EXEC;
				end
				default: begin
					if (cmd.execute) state_q <= ST_IDLE;
				end
			endcase
			if (cmd.execute) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/hte_datapath.sv -----
// Datapath for the handle table engine: input capture, handle decode,
// entry store, occupancy bitmap, free-slot search and result register.
// Uses hte_pkg and hte_ram.
module hte_datapath #(
	parameter int ENTRIES = hte_pkg::ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  hte_pkg::cmd_t               cmd,
	input  logic [hte_pkg::DATA_W-1:0]  in_data,
	input  logic [hte_pkg::USER_W-1:0]  in_user,
	output logic [hte_pkg::DATA_W-1:0]  out_data
);

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);

	// captured input word
	logic [1:0]  op_q;
	logic [31:0] object_q;
	logic [7:0]  type_q;
	logic [31:0] access_q;
	logic [31:0] attr_q;
	logic        inherit_q;
	logic        protect_q;
	logic        pseudo_q;
	logic        in_range_q;
	logic [IW-1:0] idx_q;

	// table state
	logic [ENTRIES-1:0] valid_q;
	logic [CW-1:0]      count_q;

	// result register
	logic [2:0]  status_q;
	logic [31:0] hout_q;
	logic [31:0] fobj_q;
	logic [31:0] facc_q;
	logic [31:0] fattr_q;
	logic [6:0]  in_use_q;

	// decode of the incoming handle
	logic [29:0]   hv;
	logic [29:0]   hv_m1;
	logic          in_range_n;
	logic [IW-1:0] idx_n;

	assign hv         = in_data[31:2];
	assign hv_m1      = hv - 30'd1;
	assign idx_n      = hv_m1[IW-1:0];
	assign in_range_n = (hv != 30'd0) && (hv <= 30'(ENTRIES));

	// entry store
	hte_pkg::entry_t rd_entry;
	hte_pkg::entry_t wr_entry;
	logic [hte_pkg::ENTRY_W-1:0] rd_raw;
	logic          we;
	logic [IW-1:0] waddr;

	hte_ram #(
		.WIDTH (hte_pkg::ENTRY_W),
		.DEPTH (ENTRIES)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wr_entry),
		.re    (cmd.accept),
		.raddr (idx_n),
		.rdata (rd_raw)
	);

	assign rd_entry = hte_pkg::entry_t'(rd_raw);

	// lowest free slot: isolate lowest zero of the bitmap
	logic [ENTRIES-1:0] free_oh;
	logic [IW-1:0]      free_idx;
	logic               full;
	logic [IW:0]        hslot;

	assign free_oh = ~valid_q & (valid_q + {{(ENTRIES-1){1'b0}}, 1'b1});
	assign full    = &valid_q;
	assign hslot   = {1'b0, free_idx} + {{IW{1'b0}}, 1'b1};

	always_comb begin
		free_idx = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (free_oh[i]) free_idx = free_idx | IW'(i);
		end
	end

	// evaluation
	logic          hit;
	logic [2:0]    status_n;
	logic [31:0]   hout_n;
	logic [31:0]   fobj_n;
	logic [31:0]   facc_n;
	logic [31:0]   fattr_n;
	logic          set_v;
	logic          clr_v;
	logic [CW-1:0] count_n;
	logic [CW+6:0] count_ext;

	assign hit = in_range_q && valid_q[idx_q];

	always_comb begin
		status_n = hte_pkg::ST_OK;
		hout_n   = '0;
		fobj_n   = '0;
		facc_n   = '0;
		fattr_n  = '0;
		set_v    = 1'b0;
		clr_v    = 1'b0;
		we       = 1'b0;
		waddr    = idx_q;
		wr_entry = rd_entry;
		unique case (op_q)
			hte_pkg::OP_CREATE: begin
				if (full) begin
					status_n = hte_pkg::ST_NORES;
				end else begin
					set_v    = 1'b1;
					we       = 1'b1;
					waddr    = free_idx;
					wr_entry = '{object_id: object_q, object_type: type_q,
						access: access_q, attributes: attr_q};
					hout_n   = 32'({hslot, 2'b00});
				end
			end
			hte_pkg::OP_REFERENCE: begin
				// magic token handles fall out of range here
				if (!hit) begin
					status_n = hte_pkg::ST_INVALID;
				end else if (type_q != 8'd0 && rd_entry.object_type != type_q) begin
					status_n = hte_pkg::ST_TYPE;
				end else if ((rd_entry.access & access_q) != access_q) begin
					status_n = hte_pkg::ST_ACCESS;
				end else begin
					fobj_n  = rd_entry.object_id;
					facc_n  = rd_entry.access;
					fattr_n = rd_entry.attributes;
				end
			end
			hte_pkg::OP_CLOSE: begin
				if (pseudo_q) begin
					status_n = hte_pkg::ST_OK;
				end else if (!hit) begin
					status_n = hte_pkg::ST_INVALID;
				end else if (rd_entry.attributes[hte_pkg::ATTR_PROTECT_BIT]) begin
					status_n = hte_pkg::ST_NOCLOSE;
				end else begin
					clr_v = 1'b1;
				end
			end
			default: begin
				if (pseudo_q) begin
					status_n = hte_pkg::ST_ACCESS;
				end else if (!hit) begin
					status_n = hte_pkg::ST_INVALID;
				end else begin
					we = 1'b1;
					wr_entry.attributes[hte_pkg::ATTR_INHERIT_BIT] = inherit_q;
					wr_entry.attributes[hte_pkg::ATTR_PROTECT_BIT] = protect_q;
				end
			end
		endcase
		we = we && cmd.execute;
	end

	always_comb begin
		priority if (set_v) begin
			count_n = count_q + CW'(1);
		end else if (clr_v) begin
			count_n = count_q - CW'(1);
		end else begin
			count_n = count_q;
		end
	end

	assign count_ext = {7'd0, count_n};

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (cmd.execute) begin
			count_q <= count_n;
			if (set_v) valid_q[free_idx] <= 1'b1;
			if (clr_v) valid_q[idx_q] <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q       <= in_user[1:0];
			object_q   <= in_data[63:32];
			type_q     <= in_data[71:64];
			access_q   <= in_data[103:72];
			attr_q     <= in_data[135:104];
			inherit_q  <= in_data[136];
			protect_q  <= in_data[137];
			pseudo_q   <= (in_data[31:0] >= hte_pkg::PSEUDO_FIRST);
			in_range_q <= in_range_n;
			idx_q      <= idx_n;
		end
		if (cmd.execute) begin
			status_q <= status_n;
			hout_q   <= hout_n;
			fobj_q   <= fobj_n;
			facc_q   <= facc_n;
			fattr_q  <= fattr_n;
			in_use_q <= count_ext[6:0];
		end
	end

	assign out_data = {6'd0, in_use_q, fattr_q, facc_q, fobj_q, hout_q, status_q};

endmodule

// ----- rtl/handle_table_engine_unit.sv -----
// Top level of the handle table engine: controller, datapath, assertions.
// Uses hte_pkg, hte_ctrl, hte_datapath and the assertion macro header.
//
//  channel   | dir | handshake               | payload
//  ----------+-----+-------------------------+-------------------------------------
//  s_axis    | in  | s_axis_tvalid/tready    | tuser: operation; tdata: request word
//  m_axis    | out | m_axis_tvalid/tready    | tdata: result word
//
// Per word: an accept step takes the word and reads the entry store at
// the decoded slot; an evaluate step writes the store (create, set flags),
// updates the occupancy bitmap and loads the result register. The store's
// registered read separates them; the next word waits for the evaluate step.
// Reset: clears the occupancy bitmap and count at once; no clearing pass.
// Stalls: a result waits in its register while the next word is accepted;
// the evaluate cycle holds until the result register is free.
`include "handle_table_engine_unit_assert.svh"

module handle_table_engine_unit #(
	parameter int ENTRIES = hte_pkg::ENTRIES_DEF   // table slots, 2..127
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// [31:0] handle, [63:32] object_id, [71:64] object_type,
	// [103:72] rights_mask, [135:104] attribute_bits, [136] inherit_flag,
	// [137] protect_flag, [143:138] zero
	input  logic [hte_pkg::DATA_W-1:0] s_axis_tdata,
	// [1:0] operation
	input  logic [hte_pkg::USER_W-1:0] s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// [2:0] status, [34:3] handle_out, [66:35] found_object,
	// [98:67] granted_access, [130:99] entry_attributes,
	// [137:131] entries_in_use, [143:138] zero
	output logic [hte_pkg::DATA_W-1:0] m_axis_tdata
);

	hte_pkg::cmd_t cmd;

	// sequencing: idle -> (accept) -> execute -> idle
	hte_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	// table, decode and result register
	hte_datapath #(
		.ENTRIES (ENTRIES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (s_axis_tdata),
		.in_user  (s_axis_tuser),
		.out_data (m_axis_tdata)
	);

	// one word in flight: busy in the cycle after an accept
	`HTE_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, cmd.accept, !s_axis_tready)
	// every evaluation produces a visible result next cycle
	`HTE_ASSERT_NEXT(a_result_after_exec, clk, arst_n, cmd.execute, m_axis_tvalid)
	// status stays within the defined codes
	`HTE_ASSERT_IMPL(a_status_range, clk, arst_n, m_axis_tvalid,
		m_axis_tdata[2:0] <= hte_pkg::ST_NORES)

endmodule

// ----- tb/tb_handle_table_engine_unit.sv -----
// Self-checking testbench for handle_table_engine_unit: create, reference, close and set flags
// words go in on the slave stream, and every result word is checked against an in-bench table.
// Depends on hte_pkg and the RTL of handle_table_engine_unit.
module tb_handle_table_engine_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = hte_pkg::ENTRIES_DEF;
	// top of the magic token range, which reference answers as invalid
	localparam logic [31:0] MAGIC_LAST = 32'hFFFF_FFFC;
	// cycles allowed after the last result for any stray word to show up
	localparam int TAIL_CYCLES = 8;

	// request word, handle in the lowest bits
	typedef struct packed {
		logic        protect_flag;
		logic        inherit_flag;
		logic [31:0] attribute_bits;
		logic [31:0] rights_mask;
		logic [7:0]  object_type;
		logic [31:0] object_id;
		logic [31:0] handle;
	} request_t;

	// result word, status in the lowest bits
	typedef struct packed {
		logic [6:0]  entries_in_use;
		logic [31:0] entry_attributes;
		logic [31:0] granted_access;
		logic [31:0] found_object;
		logic [31:0] handle_out;
		logic [2:0]  status;
	} reply_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        s_axis_tvalid = 1'b0;
	logic                        s_axis_tready;
	logic [hte_pkg::DATA_W-1:0]  s_axis_tdata = '0;
	logic [hte_pkg::USER_W-1:0]  s_axis_tuser = '0;
	logic                        m_axis_tvalid;
	logic                        m_axis_tready = 1'b0;
	logic [hte_pkg::DATA_W-1:0]  m_axis_tdata;

	handle_table_engine_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the handle table, updated when a word is accepted.
	logic        tbl_valid [SLOTS];
	logic [31:0] tbl_object [SLOTS];
	logic [7:0]  tbl_type [SLOTS];
	logic [31:0] tbl_access [SLOTS];
	logic [31:0] tbl_attr [SLOTS];
	int          tbl_count;

	reply_t pending_results[$];   // results owed by the block, oldest first

	int  mismatches = 0;
	int  results_checked = 0;
	int  words_sent = 0;
	int  op_sent [4];
	int  status_seen [8];
	bit  src_idle_on = 1'b1;
	bit  sink_idle_on = 1'b1;
	int  sink_wait = 0;
	int  sink_gap;
	reply_t mon_got, mon_want;

	// Gap length: mostly none, often short, now and then long.
	function automatic int pick_gap(bit en);
		int r;
		r = $urandom_range(0, 99);
		if (!en || r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Slot index for a handle, or -1 when the value is zero, out of range or free.
	function automatic int slot_of(logic [31:0] h);
		logic [31:0] value, idx;
		value = h & ~32'h3;
		if (value == 32'd0)
			return -1;
		idx = (value >> 2) - 32'd1;
		if (idx >= 32'(SLOTS))
			return -1;
		if (!tbl_valid[idx])
			return -1;
		return int'(idx);
	endfunction

	// Works out the result of one word and applies its effect to the shadow table.
	function automatic reply_t table_predict(logic [1:0] op, request_t rq);
		reply_t rp;
		int s, i;
		rp = '0;
		rp.status = hte_pkg::ST_OK;
		case (op)
			hte_pkg::OP_CREATE: begin
				s = -1;
				for (i = 0; i < SLOTS; i++)
					if (s < 0 && !tbl_valid[i])
						s = i;
				if (s < 0) begin
					rp.status = hte_pkg::ST_NORES;
				end else begin
					tbl_valid[s] = 1'b1;
					tbl_object[s] = rq.object_id;
					tbl_type[s] = rq.object_type;
					tbl_access[s] = rq.rights_mask;
					tbl_attr[s] = rq.attribute_bits;
					tbl_count++;
					rp.handle_out = 32'((s + 1) * 4);
				end
			end
			hte_pkg::OP_REFERENCE: begin
				s = slot_of(rq.handle);
				if (rq.handle >= hte_pkg::PSEUDO_FIRST && rq.handle <= MAGIC_LAST)
					rp.status = hte_pkg::ST_INVALID;   // token handles are not resolved
				else if (s < 0)
					rp.status = hte_pkg::ST_INVALID;
				else if (rq.object_type != 8'd0 && tbl_type[s] != rq.object_type)
					rp.status = hte_pkg::ST_TYPE;
				else if ((tbl_access[s] & rq.rights_mask) != rq.rights_mask)
					rp.status = hte_pkg::ST_ACCESS;
				else begin
					rp.found_object = tbl_object[s];
					rp.granted_access = tbl_access[s];
					rp.entry_attributes = tbl_attr[s];
				end
			end
			hte_pkg::OP_CLOSE: begin
				// pseudo handles close with no effect
				if (rq.handle < hte_pkg::PSEUDO_FIRST) begin
					s = slot_of(rq.handle);
					if (s < 0)
						rp.status = hte_pkg::ST_INVALID;
					else if (tbl_attr[s][hte_pkg::ATTR_PROTECT_BIT])
						rp.status = hte_pkg::ST_NOCLOSE;
					else begin
						tbl_valid[s] = 1'b0;
						if (tbl_count > 0)
							tbl_count--;
					end
				end
			end
			default: begin
				if (rq.handle >= hte_pkg::PSEUDO_FIRST) begin
					rp.status = hte_pkg::ST_ACCESS;
				end else begin
					s = slot_of(rq.handle);
					if (s < 0) begin
						rp.status = hte_pkg::ST_INVALID;
					end else begin
						tbl_attr[s][hte_pkg::ATTR_INHERIT_BIT] = rq.inherit_flag;
						tbl_attr[s][hte_pkg::ATTR_PROTECT_BIT] = rq.protect_flag;
					end
				end
			end
		endcase
		rp.entries_in_use = 7'(tbl_count);
		return rp;
	endfunction

	function automatic request_t make_rq(logic [31:0] h, logic [31:0] obj, logic [7:0] typ,
			logic [31:0] acc, logic [31:0] attr, logic inh, logic prot);
		request_t rq;
		rq.handle = h;
		rq.object_id = obj;
		rq.object_type = typ;
		rq.rights_mask = acc;
		rq.attribute_bits = attr;
		rq.inherit_flag = inh;
		rq.protect_flag = prot;
		return rq;
	endfunction

	// Handle mix: mostly live slots with random low bits, plus junk, pseudo,
	// zero-valued and just-out-of-range values.
	function automatic logic [31:0] pick_handle();
		int r, slot, k;
		r = $urandom_range(0, 99);
		if (r < 72) begin
			slot = $urandom_range(0, SLOTS - 1);
			if (tbl_count != 0 && $urandom_range(0, 9) < 8)
				for (k = 0; k < SLOTS && !tbl_valid[slot]; k++)
					slot = (slot + 1) % SLOTS;
			return 32'((slot + 1) * 4) | 32'($urandom_range(0, 3));
		end
		if (r < 82)
			return $urandom;
		if (r < 90)
			return hte_pkg::PSEUDO_FIRST + 32'($urandom_range(0, 5));
		if (r < 95)
			return 32'($urandom_range(0, 3));
		return 32'((SLOTS + 1 + $urandom_range(0, 100)) * 4) | 32'($urandom_range(0, 3));
	endfunction

	// Random request for an operation; references often aim at the target's
	// real type and a subset of its rights so that they get past the checks.
	function automatic request_t random_request(logic [1:0] op);
		request_t rq;
		int s, r;
		rq = make_rq(pick_handle(), $urandom, 8'($urandom), $urandom, $urandom,
			1'($urandom), 1'($urandom_range(0, 3) == 0));
		if ($urandom_range(0, 9) < 7)
			rq.attribute_bits[hte_pkg::ATTR_PROTECT_BIT] = 1'b0;
		if (op == hte_pkg::OP_REFERENCE) begin
			s = slot_of(rq.handle);
			r = $urandom_range(0, 99);
			if (r < 40)
				rq.object_type = 8'd0;
			else if (r < 75 && s >= 0)
				rq.object_type = tbl_type[s];
			if (s >= 0) begin
				r = $urandom_range(0, 99);
				if (r < 50)
					rq.rights_mask = tbl_access[s] & $urandom;
				else if (r < 60)
					rq.rights_mask = 32'd0;
				else if (r < 70)
					rq.rights_mask = tbl_access[s];
			end
		end
		return rq;
	endfunction

	// Drives one word, waits for its acceptance, records the owed result,
	// then maybe idles. With no gap tvalid stays high for the next word.
	task automatic send_word(logic [1:0] op, request_t rq);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {{(hte_pkg::DATA_W - $bits(request_t)){1'b0}}, rq};
		do
			@(posedge clk);
		while (!s_axis_tready);
		pending_results.push_back(table_predict(op, rq));
		words_sent++;
		op_sent[op]++;
		gap = pick_gap(src_idle_on);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Sender holds off until the block owes nothing.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		send_word(hte_pkg::OP_CREATE, make_rq('0, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFE, 1'b0, 1'b0));
		// zero object id is stored like any other
		send_word(hte_pkg::OP_CREATE, make_rq('1, 32'd0, 8'h00, 32'd0, 32'd0, 1'b1, 1'b1));
		send_word(hte_pkg::OP_CREATE, make_rq('0, 32'd1, 8'h01, 32'h0000_00F0, 32'h1,
			1'b0, 1'b0));
		send_word(hte_pkg::OP_REFERENCE, make_rq(32'd4, '0, 8'h00, 32'hFFFF_FFFF, '0,
			1'b0, 1'b0));
		send_word(hte_pkg::OP_REFERENCE, make_rq(32'd7, '0, 8'hFF, 32'd0, '0, 1'b0, 1'b0));
		send_word(hte_pkg::OP_REFERENCE, make_rq(32'd8, '1, 8'h00, 32'd0, '1, 1'b1, 1'b1));
		send_word(hte_pkg::OP_REFERENCE, make_rq(32'd12, '0, 8'h02, 32'd0, '0, 1'b0, 1'b0));
		send_word(hte_pkg::OP_REFERENCE, make_rq(32'd12, '0, 8'h01, 32'h0000_0100, '0,
			1'b0, 1'b0));
		// magic tokens and other pseudo values on reference
		send_word(hte_pkg::OP_REFERENCE, make_rq(32'hFFFF_FFFA, '0, 8'h00, 32'd0, '0,
			1'b0, 1'b0));
		send_word(hte_pkg::OP_REFERENCE, make_rq(MAGIC_LAST, '0, 8'h00, 32'd0, '0,
			1'b0, 1'b0));
		send_word(hte_pkg::OP_REFERENCE, make_rq(32'hFFFF_FFFF, '0, 8'h00, 32'd0, '0,
			1'b0, 1'b0));
		// zero value, past the end, free slot
		send_word(hte_pkg::OP_REFERENCE, make_rq(32'd3, '0, 8'h00, 32'd0, '0, 1'b0, 1'b0));
		send_word(hte_pkg::OP_REFERENCE, make_rq(32'((SLOTS + 1) * 4), '0, 8'h00, 32'd0, '0,
			1'b0, 1'b0));
		send_word(hte_pkg::OP_REFERENCE, make_rq(32'd16, '0, 8'h00, 32'd0, '0, 1'b0, 1'b0));
		// pseudo close is a no-op success, pseudo set flags is refused
		send_word(hte_pkg::OP_CLOSE, make_rq(32'hFFFF_FFFA, '0, '0, '0, '0, 1'b0, 1'b0));
		send_word(hte_pkg::OP_CLOSE, make_rq(32'hFFFF_FFFF, '0, '0, '0, '0, 1'b0, 1'b0));
		send_word(hte_pkg::OP_SETFLAGS, make_rq(32'hFFFF_FFFB, '0, '0, '0, '0, 1'b1, 1'b1));
		// protected close, unprotect, close, then stale handle
		send_word(hte_pkg::OP_CLOSE, make_rq(32'd12, '0, '0, '0, '0, 1'b0, 1'b0));
		send_word(hte_pkg::OP_SETFLAGS, make_rq(32'd12, '0, '0, '0, '0, 1'b1, 1'b0));
		send_word(hte_pkg::OP_CLOSE, make_rq(32'd14, '0, '0, '0, '0, 1'b0, 1'b0));
		send_word(hte_pkg::OP_SETFLAGS, make_rq(32'd12, '0, '0, '0, '0, 1'b1, 1'b1));
		send_word(hte_pkg::OP_CLOSE, make_rq(32'd0, '0, '0, '0, '0, 1'b0, 1'b0));
		send_word(hte_pkg::OP_SETFLAGS, make_rq(32'd5, '1, '1, '1, '1, 1'b0, 1'b1));
		send_word(hte_pkg::OP_REFERENCE, make_rq(32'd4, '0, 8'hFF, 32'h8000_0001, '0,
			1'b0, 1'b0));
		send_word(hte_pkg::OP_CLOSE, make_rq(32'd8, '0, '0, '0, '0, 1'b0, 1'b0));
	endtask

	// Fill every slot, ask for more than fit, then unprotect all and free half.
	task automatic test_fill_and_exhaust();
		int i;
		while (tbl_count < SLOTS)
			send_word(hte_pkg::OP_CREATE, random_request(hte_pkg::OP_CREATE));
		repeat (3) send_word(hte_pkg::OP_CREATE, random_request(hte_pkg::OP_CREATE));
		for (i = 0; i < SLOTS; i++)
			send_word(hte_pkg::OP_SETFLAGS,
				make_rq(32'((i + 1) * 4) | 32'($urandom_range(0, 3)),
				$urandom, 8'($urandom), $urandom, $urandom, 1'($urandom), 1'b0));
		for (i = 1; i < SLOTS; i += 2)
			send_word(hte_pkg::OP_CLOSE, make_rq(32'((i + 1) * 4), '0, '0, '0, '0,
				1'b0, 1'b0));
	endtask

	task automatic test_random_traffic(int n, int create_pct, int close_pct);
		int k, r;
		logic [1:0] op;
		for (k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < create_pct)
				op = hte_pkg::OP_CREATE;
			else if (r < create_pct + close_pct)
				op = hte_pkg::OP_CLOSE;
			else if (r < create_pct + close_pct + 15)
				op = hte_pkg::OP_SETFLAGS;
			else
				op = hte_pkg::OP_REFERENCE;
			send_word(op, random_request(op));
		end
	endtask

	// Full-rate stretch: neither side idles.
	task automatic test_back_to_back(int n);
		src_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		test_random_traffic(n, 30, 25);
		wait_drained();
		src_idle_on = 1'b1;
		sink_idle_on = 1'b1;
	endtask

	// Result sink: random back-pressure.
	always @(posedge clk) begin
		if (sink_wait > 0) begin
			sink_wait <= sink_wait - 1;
			m_axis_tready <= 1'b0;
		end else begin
			sink_gap = pick_gap(sink_idle_on);
			m_axis_tready <= (sink_gap == 0);
			sink_wait <= (sink_gap > 0) ? sink_gap - 1 : 0;
		end
	end

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	// Result checker: every accepted result word against the oldest owed one.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			mon_got = reply_t'(m_axis_tdata[$bits(reply_t)-1:0]);
			if (pending_results.size() == 0) begin
				$error("result word with none owed: 0x%0h", m_axis_tdata);
				mismatches++;
			end else begin
				mon_want = pending_results.pop_front();
				check_field("status", 32'(mon_want.status), 32'(mon_got.status));
				check_field("handle_out", mon_want.handle_out, mon_got.handle_out);
				check_field("found_object", mon_want.found_object, mon_got.found_object);
				check_field("granted_access", mon_want.granted_access, mon_got.granted_access);
				check_field("entry_attributes", mon_want.entry_attributes,
					mon_got.entry_attributes);
				check_field("entries_in_use", 32'(mon_want.entries_in_use),
					32'(mon_got.entries_in_use));
				status_seen[mon_want.status]++;
				results_checked++;
			end
		end
	end

	initial begin
		int i;
		for (i = 0; i < SLOTS; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_object[i] = '0;
			tbl_type[i] = '0;
			tbl_access[i] = '0;
			tbl_attr[i] = '0;
		end
		tbl_count = 0;
		for (i = 0; i < 4; i++)
			op_sent[i] = 0;
		for (i = 0; i < 8; i++)
			status_seen[i] = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_fill_and_exhaust();
		wait_drained();
		test_random_traffic(260, 40, 15);
		wait_drained();
		test_random_traffic(240, 25, 35);
		test_back_to_back(120);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Covered %0d words: %0d create, %0d reference, %0d close, %0d set flags.",
			words_sent, op_sent[hte_pkg::OP_CREATE], op_sent[hte_pkg::OP_REFERENCE],
			op_sent[hte_pkg::OP_CLOSE], op_sent[hte_pkg::OP_SETFLAGS]);
		$display("Checked %0d results: ok %0d, invalid %0d, type %0d, access %0d, %s %0d, %s %0d.",
			results_checked, status_seen[hte_pkg::ST_OK], status_seen[hte_pkg::ST_INVALID],
			status_seen[hte_pkg::ST_TYPE], status_seen[hte_pkg::ST_ACCESS],
			"not closable", status_seen[hte_pkg::ST_NOCLOSE], "no resources",
			status_seen[hte_pkg::ST_NORES]);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
